### rtl/tlsw_pkg.sv
package tlsw_pkg;

    // Fixed-point format of the ratio, the Michel parameters and the weight.
    localparam int FRAC_BITS = 16;

    localparam int RATIO_W  = 18;
    localparam int ENERGY_W = 24;
    localparam int MASS_W   = 16;
    localparam int PARAM_W  = 18;
    localparam int WEIGHT_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1 << FRAC_BITS);
    localparam logic [RATIO_W-1:0] RATIO_HALF = RATIO_W'(1 << (FRAC_BITS - 1));

    // Internal widths, sized for ratios in the physical range.
    localparam int X_W    = 17;   // x^2, x^3
    localparam int POLY_W = 26;   // nine-fold polynomial values
    localparam int U_W    = 24;   // unpolarized part of the weight
    localparam int G_W    = 22;   // g1 + delta*g2
    localparam int GX_W   = 20;   // xi * (g1 + delta*g2)
    localparam int QUO_W  = 33;   // quotient of the polarization division
    localparam int POL_W  = 35;

    // Pipeline depths.
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int POLY_LAT   = 8;
    localparam int POST_LAT   = 4;
    localparam int ALIGN_LAT  = DIV_LAT - POLY_LAT;
    localparam int RESULT_LAT = DIV_LAT + POST_LAT;

    // Sideband that travels with every transaction.
    typedef struct packed {
        logic valid;
        logic pos;
        logic zero;
    } tlsw_tag_t;

    typedef struct packed {
        logic [MASS_W-1:0]         tau_mass;
        logic signed [PARAM_W-1:0] rho;
        logic signed [PARAM_W-1:0] eta;
        logic signed [PARAM_W-1:0] xi;
        logic signed [PARAM_W-1:0] delta;
    } tlsw_cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAU_MASS = 3'd0,
        CFG_RHO      = 3'd1,
        CFG_ETA      = 3'd2,
        CFG_XI       = 3'd3,
        CFG_DELTA    = 3'd4
    } tlsw_cfg_idx_t;

    localparam logic [MASS_W-1:0]         TAU_MASS_RST = 16'd1777;
    localparam logic signed [PARAM_W-1:0] RHO_RST      = 18'sd49152;
    localparam logic signed [PARAM_W-1:0] ETA_RST      = 18'sd0;
    localparam logic signed [PARAM_W-1:0] XI_RST       = 18'sd65536;
    localparam logic signed [PARAM_W-1:0] DELTA_RST    = 18'sd49152;

endpackage

### rtl/tlsw_poly.sv
module tlsw_poly import tlsw_pkg::*;
(
    input  logic                   clk,
    input  logic [RATIO_W-1:0]     ratio,
    input  tlsw_cfg_t              cfg,
    output logic signed [U_W-1:0]  u,
    output logic signed [GX_W-1:0] gx
);

    // Division by 1800*S is a shift by FRAC_BITS+3 and a floor divide by 225;
    // division by 9*S is a shift by FRAC_BITS and a floor divide by 9.
    // Both constant divides run on biased, nonnegative values through a
    // reciprocal multiply.
    localparam int BIAS_EXP = 20;
    localparam int U_SHIFT  = FRAC_BITS + 3;
    localparam int WS_W     = 29;
    localparam int WG_W     = 24;
    localparam int MU_W     = 50;
    localparam int TG_W     = 42;
    localparam int PU_W     = 59;
    localparam int PG_W     = 49;
    localparam int QU_W     = 22;
    localparam int QG_W     = 21;
    localparam int U_SH     = WS_W + 8;
    localparam int G_SH     = WG_W + 4;
    localparam logic [30:0] M_U = 31'd610839794;
    localparam logic [24:0] M_G = 25'd29826162;

    localparam logic [36:0] HALF_LSB = 37'(1 << (FRAC_BITS - 1));
    localparam logic signed [POLY_W-1:0] ONE_S = POLY_W'(1 << FRAC_BITS);
    localparam logic signed [MU_W-1:0] U_BIAS =
        MU_W'(225) <<< (BIAS_EXP + U_SHIFT);
    localparam logic signed [TG_W-1:0] G_HALF = TG_W'(9 << (FRAC_BITS - 1));
    localparam logic signed [TG_W-1:0] G_BIAS =
        TG_W'(9) <<< (BIAS_EXP + FRAC_BITS);
    localparam logic signed [U_W-1:0]  U_OFS  = U_W'(1 << BIAS_EXP);
    localparam logic signed [G_W-1:0]  G_OFS  = G_W'(1 << BIAS_EXP);
    localparam logic signed [39:0]     GX_HALF = 40'(1 << (FRAC_BITS - 1));

    // Stage 0: x^2.
    logic [36:0]        sq;
    logic [RATIO_W-1:0] r0_reg;
    logic [X_W-1:0]     x2_reg;

    assign sq = 37'(ratio) * 37'(ratio) + HALF_LSB;

    always_ff @(posedge clk)
    begin
        r0_reg <= ratio;
        x2_reg <= sq[FRAC_BITS +: X_W];
    end

    // Stage 1: x^3.
    logic [36:0]        cube;
    logic [RATIO_W-1:0] r1_reg;
    logic [X_W-1:0]     x2b_reg;
    logic [X_W-1:0]     x3_reg;

    assign cube = 37'(x2_reg) * 37'(r0_reg) + HALF_LSB;

    always_ff @(posedge clk)
    begin
        r1_reg  <= r0_reg;
        x2b_reg <= x2_reg;
        x3_reg  <= cube[FRAC_BITS +: X_W];
    end

    // Stage 2: the five polynomials, scaled by nine.
    logic signed [POLY_W-1:0] rs, x2s, x3s;
    logic signed [POLY_W-1:0] f0_next, f1_next, f2_next, g1_next, g2_next;
    logic signed [POLY_W-1:0] f0_reg, f1_reg, f2_reg, g1_reg, g2_reg;

    always_comb
    begin
        rs  = $signed(POLY_W'(r1_reg));
        x2s = $signed(POLY_W'(x2b_reg));
        x3s = $signed(POLY_W'(x3_reg));
        f0_next = 26'sd18 * ONE_S - 26'sd54 * x2s + 26'sd36 * x3s;
        f1_next = 26'sd36 * x2s - 26'sd4 * ONE_S - 26'sd32 * x3s;
        f2_next = 26'sd108 * (ONE_S - 26'sd2 * rs + x2s);
        g1_next = 26'sd36 * rs - 26'sd6 * ONE_S - 26'sd54 * x2s + 26'sd24 * x3s;
        g2_next = 26'sd4 * ONE_S - 26'sd48 * rs + 26'sd108 * x2s - 26'sd64 * x3s;
    end

    always_ff @(posedge clk)
    begin
        f0_reg <= f0_next;
        f1_reg <= f1_next;
        f2_reg <= f2_next;
        g1_reg <= g1_next;
        g2_reg <= g2_next;
    end

    // Stage 3: products with the Michel parameters.
    logic signed [43:0]       rhof1_reg, etaf2_reg, deltag2_reg;
    logic signed [POLY_W-1:0] f0p_reg, g1p_reg;

    always_ff @(posedge clk)
    begin
        rhof1_reg   <= 44'($signed(cfg.rho)) * 44'(f1_reg);
        etaf2_reg   <= 44'($signed(cfg.eta)) * 44'(f2_reg);
        deltag2_reg <= 44'($signed(cfg.delta)) * 44'(g2_reg);
        f0p_reg     <= f0_reg;
        g1p_reg     <= g1_reg;
    end

    // Stage 4: rounded numerators with bias, then the power-of-two part.
    logic signed [MU_W-1:0] mu;
    logic signed [TG_W-1:0] tg;
    logic [WS_W-1:0]        ws_reg;
    logic [WG_W-1:0]        wg_reg;

    always_comb
    begin
        mu = MU_W'(rhof1_reg) * 50'sd200 + MU_W'(etaf2_reg) * 50'sd11
           + ((MU_W'(f0p_reg) * 50'sd200 + 50'sd900) <<< FRAC_BITS) + U_BIAS;
        tg = (TG_W'(g1p_reg) <<< FRAC_BITS) + TG_W'(deltag2_reg) + G_HALF + G_BIAS;
    end

    always_ff @(posedge clk)
    begin
        ws_reg <= mu[U_SHIFT +: WS_W];
        wg_reg <= tg[FRAC_BITS +: WG_W];
    end

    // Stage 5: reciprocal multiplies for /225 and /9.
    logic [PU_W-1:0] pu;
    logic [PG_W-1:0] pg;
    logic [QU_W-1:0] qu_reg;
    logic [QG_W-1:0] qg_reg;

    assign pu = PU_W'(ws_reg) * PU_W'(M_U);
    assign pg = PG_W'(wg_reg) * PG_W'(M_G);

    always_ff @(posedge clk)
    begin
        qu_reg <= pu[U_SH +: QU_W];
        qg_reg <= pg[G_SH +: QG_W];
    end

    // Stage 6: remove the bias.
    logic signed [U_W-1:0] u6_reg;
    logic signed [G_W-1:0] g_reg;

    always_ff @(posedge clk)
    begin
        u6_reg <= $signed(U_W'(qu_reg)) - U_OFS;
        g_reg  <= $signed(G_W'(qg_reg)) - G_OFS;
    end

    // Stage 7: scale by xi with rounding.
    logic signed [39:0]     gxp;
    logic signed [U_W-1:0]  u7_reg;
    logic signed [GX_W-1:0] gx_reg;

    assign gxp = 40'(g_reg) * 40'($signed(cfg.xi)) + GX_HALF;

    always_ff @(posedge clk)
    begin
        u7_reg <= u6_reg;
        gx_reg <= gxp[FRAC_BITS +: GX_W];
    end

    assign u  = u7_reg;
    assign gx = gx_reg;

endmodule

### rtl/tlsw_div.sv
module tlsw_div import tlsw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tlsw_tag_t           in_tag,
    input  logic [RATIO_W-1:0]  ratio,
    input  logic [ENERGY_W-1:0] energy,
    input  logic [MASS_W-1:0]   tau_mass,
    output tlsw_tag_t           out_tag,
    output logic [QUO_W-1:0]    quo
);

    // Restoring division, one quotient bit per stage. Each stage word holds
    // the dividend bits still to be consumed and the quotient bits so far.
    logic [QUO_W:0]  num;
    tlsw_tag_t       tag_reg [0:DIV_STEPS];
    logic [QUO_W-1:0] dq_reg [0:DIV_STEPS];
    logic [ENERGY_W-1:0] rem_reg [0:DIV_STEPS];
    logic [ENERGY_W-1:0] den_reg [0:DIV_STEPS];
    logic [ENERGY_W:0]   trial [0:DIV_STEPS-1];
    logic                ge [0:DIV_STEPS-1];

    assign num = (QUO_W+1)'(tau_mass) * (QUO_W+1)'(ratio)
               + (QUO_W+1)'(energy >> 1);

    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial[i] = {rem_reg[i], dq_reg[i][QUO_W-1]};
            ge[i]    = trial[i] >= {1'b0, den_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg[0]  <= num[QUO_W-1:0];
        rem_reg[0] <= '0;
        den_reg[0] <= energy;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            dq_reg[i+1]  <= {dq_reg[i][QUO_W-2:0], ge[i]};
            rem_reg[i+1] <= ge[i] ? ENERGY_W'(trial[i] - {1'b0, den_reg[i]})
                                  : trial[i][ENERGY_W-1:0];
            den_reg[i+1] <= den_reg[i];
        end
    end

    assign out_tag = tag_reg[DIV_STEPS];
    assign quo     = dq_reg[DIV_STEPS];

endmodule

### rtl/tlsw_post.sv
module tlsw_post import tlsw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlsw_tag_t                  in_tag,
    input  logic [QUO_W-1:0]           quo,
    input  logic signed [U_W-1:0]      u,
    input  logic signed [GX_W-1:0]     gx,
    output logic                       done,
    output logic signed [WEIGHT_W-1:0] weight,
    output logic                       saturated
);

    localparam int SPLIT = 17;
    localparam int PP_W  = GX_W + SPLIT + 1;
    localparam int PS_W  = 56;
    localparam int W_W   = PS_W - FRAC_BITS + 1;
    localparam logic signed [POL_W-1:0] ONE_POL = POL_W'(1 << FRAC_BITS);
    localparam logic signed [PS_W-1:0]  HALF_LSB = PS_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [W_W-1:0]   W_MAX = W_W'((1 << (WEIGHT_W - 1)) - 1);
    localparam logic signed [W_W-1:0]   W_MIN = -W_W'(1 << (WEIGHT_W - 1));

    tlsw_tag_t tag_reg [0:POST_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POST_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < POST_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Stage 0: signed polarization.
    logic signed [POL_W-1:0] pol0;
    logic signed [POL_W-1:0] pol_reg;
    logic signed [GX_W-1:0]  gx0_reg;
    logic signed [U_W-1:0]   u0_reg;

    assign pol0 = $signed(POL_W'(quo)) - ONE_POL;

    always_ff @(posedge clk)
    begin
        pol_reg <= in_tag.pos ? -pol0 : pol0;
        gx0_reg <= gx;
        u0_reg  <= u;
    end

    // Stage 1: the product is split into two narrow partial products.
    logic signed [SPLIT:0]  pl;
    logic signed [POL_W-SPLIT-1:0] ph;
    logic signed [PP_W-1:0] hi_reg, lo_reg;
    logic signed [U_W-1:0]  u1_reg;

    assign ph = pol_reg[POL_W-1:SPLIT];
    assign pl = $signed({1'b0, pol_reg[SPLIT-1:0]});

    always_ff @(posedge clk)
    begin
        hi_reg <= PP_W'(gx0_reg) * PP_W'(ph);
        lo_reg <= PP_W'(gx0_reg) * PP_W'(pl);
        u1_reg <= u0_reg;
    end

    // Stage 2: combine with rounding.
    logic signed [PS_W-1:0] psum_reg;
    logic signed [U_W-1:0]  u2_reg;

    always_ff @(posedge clk)
    begin
        psum_reg <= (PS_W'(hi_reg) <<< SPLIT) + PS_W'(lo_reg) + HALF_LSB;
        u2_reg   <= u1_reg;
    end

    // Stage 3: difference, clipping and the out-of-range zero.
    logic signed [W_W-1:0] w;
    logic                  done_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                  sat_reg;

    assign w = W_W'(u2_reg) - W_W'($signed(psum_reg[PS_W-1:FRAC_BITS]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_reg[2].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg[2].zero)
        begin
            weight_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else if (w > W_MAX)
        begin
            weight_reg <= W_MAX[WEIGHT_W-1:0];
            sat_reg    <= 1'b1;
        end
        else if (w < W_MIN)
        begin
            weight_reg <= W_MIN[WEIGHT_W-1:0];
            sat_reg    <= 1'b1;
        end
        else
        begin
            weight_reg <= w[WEIGHT_W-1:0];
            sat_reg    <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign weight    = weight_reg;
    assign saturated = sat_reg;

endmodule

### rtl/tau_lepton_spectrum_weight_unit.sv
// Depth: done is registered; the pipeline depth is set by the 33-step
// polarization divider plus its operand stage and four output stages.
// Throughput: one transaction per clock cycle, every cycle once busy is low.
// Reset: rst_n clears all valid bits and restores the configuration registers
// to their default values; busy is high until the ready register is set after reset.
// There is no result back-pressure: each result is shown for one cycle only.
module tau_lepton_spectrum_weight_unit import tlsw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [RATIO_W-1:0]         energy_ratio,
    input  logic [ENERGY_W-1:0]        measured_energy,
    input  logic                       positive_charge,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [PARAM_W-1:0]         cfg_data,
    output logic                       done,
    output logic signed [WEIGHT_W-1:0] weight,
    output logic                       saturated
);

    // Configuration registers. They are to be written only while no transaction is
    // in flight (the block itself does not enforce this), so every pipeline stage reads them directly.
    tlsw_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tau_mass <= TAU_MASS_RST;
            cfg_reg.rho      <= RHO_RST;
            cfg_reg.eta      <= ETA_RST;
            cfg_reg.xi       <= XI_RST;
            cfg_reg.delta    <= DELTA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAU_MASS: cfg_reg.tau_mass <= cfg_data[MASS_W-1:0];
                CFG_RHO:      cfg_reg.rho      <= $signed(cfg_data);
                CFG_ETA:      cfg_reg.eta      <= $signed(cfg_data);
                CFG_XI:       cfg_reg.xi       <= $signed(cfg_data);
                CFG_DELTA:    cfg_reg.delta    <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    // The block becomes ready in the cycle after reset is released and stays ready.
    logic ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy = !ready_reg;

    // A transaction with zero energy or a ratio outside one half to one
    // carries a flag that forces a zero weight at the output.
    tlsw_tag_t in_tag;

    always_comb
    begin
        in_tag.valid = start && ready_reg;
        in_tag.pos   = positive_charge;
        in_tag.zero  = (measured_energy == '0) || (energy_ratio < RATIO_HALF)
                    || (energy_ratio > RATIO_ONE);
    end

    // Polynomial path: unpolarized weight and the xi-scaled asymmetry term.
    logic signed [U_W-1:0]  poly_u;
    logic signed [GX_W-1:0] poly_gx;

    tlsw_poly u_poly (
        .clk   (clk),
        .ratio (energy_ratio),
        .cfg   (cfg_reg),
        .u     (poly_u),
        .gx    (poly_gx)
    );

    // Polarization path: rounded tau_mass*ratio/energy.
    tlsw_tag_t        div_tag;
    logic [QUO_W-1:0] div_quo;

    tlsw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (in_tag),
        .ratio    (energy_ratio),
        .energy   (measured_energy),
        .tau_mass (cfg_reg.tau_mass),
        .out_tag  (div_tag),
        .quo      (div_quo)
    );

    // The polynomial path is shorter than the divider; a delay line lines
    // its results up with the quotient of the same transaction.
    logic signed [U_W-1:0]  u_dly_reg  [0:ALIGN_LAT-1];
    logic signed [GX_W-1:0] gx_dly_reg [0:ALIGN_LAT-1];

    always_ff @(posedge clk)
    begin
        u_dly_reg[0]  <= poly_u;
        gx_dly_reg[0] <= poly_gx;
        for (int i = 1; i < ALIGN_LAT; i++)
        begin
            u_dly_reg[i]  <= u_dly_reg[i-1];
            gx_dly_reg[i] <= gx_dly_reg[i-1];
        end
    end

    // Output stages: polarization product, rounding and clipping.
    tlsw_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (div_tag),
        .quo       (div_quo),
        .u         (u_dly_reg[ALIGN_LAT-1]),
        .gx        (gx_dly_reg[ALIGN_LAT-1]),
        .done      (done),
        .weight    (weight),
        .saturated (saturated)
    );

endmodule

### rtl/tlsw_checker.sv
module tlsw_checker import tlsw_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [RATIO_W-1:0]         energy_ratio,
    input logic [ENERGY_W-1:0]        measured_energy,
    input logic                       done,
    input logic signed [WEIGHT_W-1:0] weight,
    input logic                       saturated
);

    logic accept;
    logic out_of_range;

    assign accept       = start && !busy;
    assign out_of_range = (measured_energy == '0) || (energy_ratio < RATIO_HALF)
                       || (energy_ratio > RATIO_ONE);

    // Every result belongs to a transaction taken a fixed time earlier.
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, RESULT_LAT))
        else $error("result without a matching transaction");

    // Out-of-range transactions produce a clean zero.
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && out_of_range, RESULT_LAT)
        |-> (weight == '0) && !saturated)
        else $error("nonzero weight for out-of-range transaction");

    // A clipped weight sits on one of the range limits.
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> (weight == 24'sh7FFFFF) || (weight == 24'sh800000))
        else $error("saturated weight not at a limit");

    // Once ready after reset, the unit never refuses a transaction.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy raised after reset");

endmodule

bind tau_lepton_spectrum_weight_unit tlsw_checker u_tlsw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .energy_ratio    (energy_ratio),
    .measured_energy (measured_energy),
    .done            (done),
    .weight          (weight),
    .saturated       (saturated)
);
